// File: rtl/emb_pkg.sv
// Shared types and codes for the extent map block translator.
package emb_pkg;

    typedef enum logic [2:0] {
        K_LOAD     = 3'd0,
        K_SEEK_BLK = 3'd1,
        K_NEXT_BLK = 3'd2,
        K_SEEK_EXT = 3'd3,
        K_NEXT_EXT = 3'd4,
        K_REMAIN   = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_EXEC,
        ST_REM,
        ST_OUT
    } st_t;

    // One entry as seen on the shared read chain.
    typedef struct packed {
        logic [63:0] start;
        logic [63:0] len;
        logic [63:0] lo;
        logic [63:0] off;
    } rd_t;

    // Write of one entry, broadcast along the row.
    typedef struct packed {
        logic        en;
        logic [63:0] start;
        logic [63:0] len;
        logic [63:0] last;
    } wr_t;

endpackage

// File: rtl/extent_map_block_translator_top.sv
// Top level of the extent map block translator.
//
// The block keeps a map of up to MAX_EXTENTS file extents in a row of cells, each cell
// holding one extent's physical start, length and running logical end, and a cursor
// that walks the map. Every item on the slave stream is one command (load, seek block,
// next block, seek extent, next extent, remaining to target) and produces exactly one
// result item on the master stream. An item passes in order through acceptance,
// a compare cycle in which every cell tests the seek block against its range in
// parallel, an execute cycle that reads one entry over the cells' read chain and
// updates the cursor, a cycle forming the cursor's remainders, and one loading the
// output register. The next item is taken as soon as the block is back in idle, even
// while the previous result still waits in the output register; a result that cannot
// leave holds the block in its last cycle. No clearing pass follows reset: the map is
// empty and unwritten entries are never relied upon.
module extent_map_block_translator_top
    import emb_pkg::*;
#(
    parameter int MAX_EXTENTS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // extent_start[63:0], extent_length[127:64], block_number[191:128],
    // extent_index[195:192], zero pad [199:196]
    input  logic [199:0] s_tdata,
    // kind[2:0], restart_map[3]
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // ok[0], logical_block[64:1], physical_block[128:65], extent_position[132:129],
    // total_blocks[196:133], extent_total[201:197], at_last_block[202],
    // at_last_extent[203], remaining_in_extent[267:204],
    // remaining_to_target[331:268], zero pad [335:332]
    output logic [335:0] m_tdata
);

    localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CNT_W = $clog2(MAX_EXTENTS + 1);

    st_t st_reg, st_next;

    // Command held for the whole of its processing.
    logic [2:0]  kind_reg;
    logic        restart_reg;
    logic [63:0] xstart_reg;
    logic [63:0] xlen_reg;
    logic [63:0] blk_reg;
    logic [3:0]  xidx_reg;

    // Map totals and cursor; cur_lo and cur_len cache the cursor extent's range.
    logic [CNT_W-1:0] count_reg, count_next;
    logic [63:0]      sum_reg, sum_next;
    logic [63:0]      log_reg, log_next;
    logic [63:0]      phys_reg, phys_next;
    logic [IDX_W-1:0] ext_reg, ext_next;
    logic [63:0]      cur_lo_reg, cur_lo_next;
    logic [63:0]      cur_len_reg, cur_len_next;
    logic             ok_reg, ok_next;

    logic [63:0] left_reg;
    logic [63:0] to_blk_reg;
    logic        ahead_reg;

    logic         m_tvalid_reg;
    logic [335:0] m_tdata_reg;

    // Cell row chains.
    logic [63:0]      ends_c   [0:MAX_EXTENTS];
    rd_t              rd_c     [0:MAX_EXTENTS];
    logic             hit_c    [0:MAX_EXTENTS];
    logic [IDX_W-1:0] hit_idx_c[0:MAX_EXTENTS];

    wr_t              wr;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] ext_wrap;
    logic [CNT_W-1:0] eff_cnt;
    logic [63:0]      log_inc;
    logic [63:0]      sum_base;
    rd_t              rd;
    logic             out_free;
    logic [63:0]      rtt;
    logic             last_blk;
    logic             last_ext;

    assign ends_c[0]    = '0;
    assign rd_c[0]      = '0;
    assign hit_c[0]     = 1'b0;
    assign hit_idx_c[0] = '0;
    assign rd           = rd_c[MAX_EXTENTS];

    for (genvar i = 0; i < MAX_EXTENTS; i++)
    begin : g_cell
        emb_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .wr          (wr),
            .wr_idx      (wr_idx),
            .lo_in       (ends_c[i]),
            .end_out     (ends_c[i+1]),
            .cmp_en      (st_reg == ST_CMP),
            .count       (count_reg),
            .blk         (blk_reg),
            .rd_addr     (rd_addr),
            .rd_in       (rd_c[i]),
            .rd_out      (rd_c[i+1]),
            .hit_in      (hit_c[i]),
            .hit_idx_in  (hit_idx_c[i]),
            .hit_out     (hit_c[i+1]),
            .hit_idx_out (hit_idx_c[i+1])
        );
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer.
    always_comb
    begin
        st_next  = st_reg;
        s_tready = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    st_next = ST_CMP;
                end
            end
            ST_CMP:  st_next = ST_EXEC;
            ST_EXEC: st_next = ST_REM;
            ST_REM:  st_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // The next extent after the cursor, wrapping past the end of the table.
    assign ext_wrap = (ext_reg == IDX_W'(MAX_EXTENTS - 1)) ? '0 : ext_reg + 1'b1;
    assign eff_cnt  = restart_reg ? '0 : count_reg;
    assign sum_base = restart_reg ? '0 : sum_reg;
    assign log_inc  = log_reg + 64'd1;

    // Execute: one entry is read over the chain and the cursor is updated.
    always_comb
    begin
        count_next   = count_reg;
        sum_next     = sum_reg;
        log_next     = log_reg;
        phys_next    = phys_reg;
        ext_next     = ext_reg;
        cur_lo_next  = cur_lo_reg;
        cur_len_next = cur_len_reg;
        ok_next      = 1'b0;
        wr.en        = 1'b0;
        wr.start     = xstart_reg;
        wr.len       = xlen_reg;
        wr.last      = sum_base + xlen_reg;
        wr_idx       = IDX_W'(eff_cnt);
        rd_addr      = '0;
        unique case (kind_reg)
            K_LOAD:
            begin
                if (int'(eff_cnt) < MAX_EXTENTS)
                begin
                    wr.en        = (st_reg == ST_EXEC);
                    sum_next     = sum_base + xlen_reg;
                    count_next   = eff_cnt + 1'b1;
                    ext_next     = '0;
                    log_next     = '0;
                    cur_lo_next  = '0;
                    // Entry 0 may be the one being written in this cycle.
                    phys_next    = (wr_idx == '0) ? xstart_reg : rd.start;
                    cur_len_next = (wr_idx == '0) ? xlen_reg : rd.len;
                    ok_next      = 1'b1;
                end
            end
            K_SEEK_BLK:
            begin
                rd_addr = hit_idx_c[MAX_EXTENTS];
                if (blk_reg < sum_reg)
                begin
                    log_next = blk_reg;
                    if (hit_c[MAX_EXTENTS])
                    begin
                        phys_next    = rd.start + rd.off;
                        ext_next     = hit_idx_c[MAX_EXTENTS];
                        cur_lo_next  = rd.lo;
                        cur_len_next = rd.len;
                    end
                    ok_next = 1'b1;
                end
            end
            K_NEXT_BLK:
            begin
                rd_addr = ext_wrap;
                if (!(log_reg >= sum_reg - 64'd1))
                begin
                    log_next = log_inc;
                    if ((log_inc - cur_lo_reg) < cur_len_reg)
                    begin
                        phys_next = phys_reg + 64'd1;
                    end
                    else
                    begin
                        ext_next     = ext_wrap;
                        phys_next    = rd.start;
                        cur_lo_next  = rd.lo;
                        cur_len_next = rd.len;
                    end
                    ok_next = 1'b1;
                end
            end
            K_SEEK_EXT:
            begin
                rd_addr = IDX_W'(xidx_reg);
                if ((int'(xidx_reg) < int'(count_reg)) && (int'(xidx_reg) < MAX_EXTENTS))
                begin
                    ext_next     = IDX_W'(xidx_reg);
                    log_next     = rd.lo;
                    phys_next    = rd.start;
                    cur_lo_next  = rd.lo;
                    cur_len_next = rd.len;
                    ok_next      = 1'b1;
                end
            end
            K_NEXT_EXT:
            begin
                rd_addr = ext_wrap;
                if ((int'(ext_reg) + 1) < int'(count_reg))
                begin
                    ext_next     = ext_wrap;
                    log_next     = rd.lo;
                    phys_next    = rd.start;
                    cur_lo_next  = rd.lo;
                    cur_len_next = rd.len;
                    ok_next      = 1'b1;
                end
            end
            K_REMAIN: ok_next = 1'b1;
            default:  ok_next = 1'b0;
        endcase
    end

    // Status of the updated cursor, formed while the output register is loaded.
    assign rtt      = !ahead_reg ? '0 : ((left_reg < to_blk_reg) ? left_reg : to_blk_reg);
    assign last_blk = log_reg >= sum_reg - 64'd1;
    assign last_ext = (int'(ext_reg) + 1) >= int'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_IDLE;
            count_reg    <= '0;
            sum_reg      <= '0;
            log_reg      <= '0;
            phys_reg     <= '0;
            ext_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == ST_EXEC)
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                log_reg   <= log_next;
                phys_reg  <= phys_next;
                ext_reg   <= ext_next;
            end
            if (st_reg == ST_OUT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && s_tvalid)
        begin
            kind_reg    <= s_tuser[2:0];
            restart_reg <= s_tuser[3];
            xstart_reg  <= s_tdata[63:0];
            xlen_reg    <= s_tdata[127:64];
            blk_reg     <= s_tdata[191:128];
            xidx_reg    <= s_tdata[195:192];
        end
        if (st_reg == ST_EXEC)
        begin
            cur_lo_reg  <= cur_lo_next;
            cur_len_reg <= cur_len_next;
            ok_reg      <= ok_next;
        end
        if (st_reg == ST_REM)
        begin
            left_reg   <= cur_len_reg - (log_reg - cur_lo_reg);
            to_blk_reg <= blk_reg - log_reg;
            ahead_reg  <= blk_reg > log_reg;
        end
        if (st_reg == ST_OUT && out_free)
        begin
            m_tdata_reg <= {4'b0, rtt, left_reg, last_ext, last_blk,
                            5'(count_reg), sum_reg, 4'(ext_reg), phys_reg, log_reg, ok_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/emb_cell.sv
// One extent cell: holds an entry, compares a seek block and joins the read and hit chains.
module emb_cell
    import emb_pkg::*;
#(
    parameter int IDX_W = 4,
    parameter int CNT_W = 5,
    parameter int INDEX = 0
)
(
    input  logic             clk,
    input  wr_t              wr,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [63:0]      lo_in,
    output logic [63:0]      end_out,
    input  logic             cmp_en,
    input  logic [CNT_W-1:0] count,
    input  logic [63:0]      blk,
    input  logic [IDX_W-1:0] rd_addr,
    input  rd_t              rd_in,
    output rd_t              rd_out,
    input  logic             hit_in,
    input  logic [IDX_W-1:0] hit_idx_in,
    output logic             hit_out,
    output logic [IDX_W-1:0] hit_idx_out
);

    logic [63:0] start_reg;
    logic [63:0] len_reg;
    logic [63:0] end_reg;
    logic [63:0] off_reg;
    logic        match_reg;
    rd_t         mine;

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr_idx == IDX_W'(INDEX)))
        begin
            start_reg <= wr.start;
            len_reg   <= wr.len;
            end_reg   <= wr.last;
        end
        if (cmp_en)
        begin
            match_reg <= (CNT_W'(INDEX) < count) && (lo_in <= blk) && (blk < end_reg);
            off_reg   <= blk - lo_in;
        end
    end

    assign end_out = end_reg;

    always_comb
    begin
        mine.start = start_reg;
        mine.len   = len_reg;
        mine.lo    = lo_in;
        mine.off   = off_reg;
        rd_out     = (rd_addr == IDX_W'(INDEX)) ? (rd_in | mine) : rd_in;
    end

    // Later cells win, so the highest matching index comes out of the row.
    assign hit_out     = match_reg | hit_in;
    assign hit_idx_out = match_reg ? IDX_W'(INDEX) : hit_idx_in;

endmodule

// File: rtl/emb_checker.sv
// Port-level checks of the extent map block translator and their binding.
module emb_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [335:0] m_tdata
);

    // A waiting result holds still.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Commands are handled one at a time.
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while busy");

    a_rtt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[331:268] <= m_tdata[267:204])
        else $error("remaining to target exceeds extent remainder");

    // Not at the last extent means a later extent is loaded.
    a_ext: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[203] |-> ({1'b0, m_tdata[132:129]} + 5'd1) < m_tdata[201:197])
        else $error("last extent flag inconsistent");

endmodule

bind extent_map_block_translator_top emb_checker u_emb_checker (.*);
